/* hw/rtl/stable_priority_queue_unit_macros.svh */
// Assertion macros used by the queue datapath RTL.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SPQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SPQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/spq_pkg.sv */
package spq_pkg;

   localparam int ITEM_W = 16;
   localparam int KIND_W = 16;
   localparam int PRIO_W = 16;
   localparam int STAT_W = 2;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } spq_req_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_DUP   = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } spq_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_COMMIT
   } spq_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic eval;
      logic commit;
   } spq_cmd_type;

endpackage

/* hw/rtl/spq_req_if.sv */
interface spq_req_if import spq_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [ITEM_W-1:0]        item_id;
   logic [KIND_W-1:0]        new_kind;
   logic signed [PRIO_W-1:0] new_prio;

   modport source (output valid, req_type, item_id, new_kind, new_prio, input ready);
   modport sink   (input valid, req_type, item_id, new_kind, new_prio, output ready);
endinterface

/* hw/rtl/spq_rsp_if.sv */
interface spq_rsp_if import spq_pkg::*; #(parameter int CNT_W = 5) ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic [CNT_W-1:0]         old_count;
   logic [ITEM_W-1:0]        out_item;
   logic [KIND_W-1:0]        out_kind;
   logic signed [PRIO_W-1:0] out_prio;
   logic [CNT_W-1:0]         entry_count;

   modport source (output valid, status, old_count, out_item, out_kind, out_prio,
                   entry_count, input ready);
   modport sink   (input valid, status, old_count, out_item, out_kind, out_prio,
                   entry_count, output ready);
endinterface

/* hw/rtl/spq_ctrl.sv */
module spq_ctrl import spq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output spq_cmd_type cmd
);

   spq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // The result register must be free before the slots are updated.
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.load = 1'b1;
                  state_in = ST_EVAL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/spq_dpath.sv */
`include "stable_priority_queue_unit_macros.svh"

module spq_dpath import spq_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int CNT_W = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  spq_cmd_type              cmd,
   input  logic                     req_type,
   input  logic [ITEM_W-1:0]        item_id,
   input  logic [KIND_W-1:0]        new_kind,
   input  logic signed [PRIO_W-1:0] new_prio,
   output logic [STAT_W-1:0]        status,
   output logic [CNT_W-1:0]         old_count,
   output logic [ITEM_W-1:0]        out_item,
   output logic [KIND_W-1:0]        out_kind,
   output logic signed [PRIO_W-1:0] out_prio,
   output logic [CNT_W-1:0]         entry_count
);

   // Sorted slots, head at index 0; only slots below count_ff hold entries.
   logic [ITEM_W-1:0]        slot_item_ff [DEPTH];
   logic [KIND_W-1:0]        slot_kind_ff [DEPTH];
   logic signed [PRIO_W-1:0] slot_prio_ff [DEPTH];
   logic [ITEM_W-1:0]        slot_item_in [DEPTH];
   logic [KIND_W-1:0]        slot_kind_in [DEPTH];
   logic signed [PRIO_W-1:0] slot_prio_in [DEPTH];
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                     req_type_ff;
   logic [ITEM_W-1:0]        item_ff;
   logic [KIND_W-1:0]        kind_ff;
   logic signed [PRIO_W-1:0] prio_ff;

   // Per-slot compare results: identifier match and "goes ahead of the new entry".
   logic [DEPTH-1:0] match_ff, match_in;
   logic [DEPTH-1:0] ahead_ff, ahead_in;

   logic [STAT_W-1:0]        status_ff, status_in;
   logic [CNT_W-1:0]         old_count_ff, old_count_in;
   logic [ITEM_W-1:0]        out_item_ff, out_item_in;
   logic [KIND_W-1:0]        out_kind_ff, out_kind_in;
   logic signed [PRIO_W-1:0] out_prio_ff, out_prio_in;

   logic is_dup, is_full, is_empty;

   assign is_dup   = |match_ff;
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (CNT_W'(i) < count_ff) && (slot_item_ff[i] == item_ff);
         ahead_in[i] = (CNT_W'(i) < count_ff) && (slot_prio_ff[i] <= prio_ff);
      end
   end

   always_comb begin
      slot_item_in = slot_item_ff;
      slot_kind_in = slot_kind_ff;
      slot_prio_in = slot_prio_ff;
      count_in     = count_ff;
      status_in    = STAT_OK;
      old_count_in = '0;
      out_item_in  = '0;
      out_kind_in  = '0;
      out_prio_in  = '0;
      if (req_type_ff == REQ_INSERT) begin
         if (is_dup) begin
            status_in = STAT_DUP;
         end else if (is_full) begin
            status_in = STAT_FULL;
         end else begin
            old_count_in = count_ff;
            count_in     = count_ff + 1'b1;
            // Slots ahead of the new entry hold; the first one behind takes it,
            // and the rest move back by one.
            if (!ahead_ff[0]) begin
               slot_item_in[0] = item_ff;
               slot_kind_in[0] = kind_ff;
               slot_prio_in[0] = prio_ff;
            end
            for (int i = 1; i < DEPTH; i++) begin
               if (!ahead_ff[i]) begin
                  if (ahead_ff[i-1]) begin
                     slot_item_in[i] = item_ff;
                     slot_kind_in[i] = kind_ff;
                     slot_prio_in[i] = prio_ff;
                  end else begin
                     slot_item_in[i] = slot_item_ff[i-1];
                     slot_kind_in[i] = slot_kind_ff[i-1];
                     slot_prio_in[i] = slot_prio_ff[i-1];
                  end
               end
            end
         end
      end else begin
         if (is_empty) begin
            status_in = STAT_EMPTY;
         end else begin
            out_item_in = slot_item_ff[0];
            out_kind_in = slot_kind_ff[0];
            out_prio_in = slot_prio_ff[0];
            count_in    = count_ff - 1'b1;
            for (int i = 0; i < DEPTH - 1; i++) begin
               slot_item_in[i] = slot_item_ff[i+1];
               slot_kind_in[i] = slot_kind_ff[i+1];
               slot_prio_in[i] = slot_prio_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff <= req_type;
         item_ff     <= item_id;
         kind_ff     <= new_kind;
         prio_ff     <= new_prio;
      end
      if (cmd.eval) begin
         match_ff <= match_in;
         ahead_ff <= ahead_in;
      end
      if (cmd.commit) begin
         slot_item_ff <= slot_item_in;
         slot_kind_ff <= slot_kind_in;
         slot_prio_ff <= slot_prio_in;
         status_ff    <= status_in;
         old_count_ff <= old_count_in;
         out_item_ff  <= out_item_in;
         out_kind_ff  <= out_kind_in;
         out_prio_ff  <= out_prio_in;
      end
   end

   assign status      = status_ff;
   assign old_count   = old_count_ff;
   assign out_item    = out_item_ff;
   assign out_kind    = out_kind_ff;
   assign out_prio    = out_prio_ff;
   assign entry_count = count_ff;

   `SPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH),
                   "count above depth")
   `SPQ_ASSERT_NOW(a_ahead_prefix, clock, reset, cmd.commit,
                   ((ahead_ff + 1'b1) & ahead_ff) == '0,
                   "ahead flags not a prefix of the sorted slots")
   `SPQ_ASSERT_NOW(a_unique_ids, clock, reset, cmd.commit, $onehot0(match_ff),
                   "identifier held in more than one slot")
   `SPQ_ASSERT_NEXT(a_insert_count, clock, reset,
                    cmd.commit && req_type_ff == REQ_INSERT && !is_dup && !is_full,
                    count_ff == $past(count_ff) + 1'b1, "insert did not grow count")
endmodule

/* hw/rtl/stable_priority_queue_unit.sv */
// Channel   Dir  Handshake        Transfer contents
// req_chan  in   valid / ready    req_type, item_id, new_kind, new_prio
// rsp_chan  out  valid / ready    status, old_count, out_item, out_kind, out_prio, entry_count
//
// Each request is compared against all slots in parallel (ST_EVAL), then the slots are shifted
// and the result register loaded (ST_COMMIT).
// A new request is taken in the same cycle its predecessor's result is loaded.
// Reset is synchronous and empties the queue; slot contents are not cleared.
// A result held by a stalled rsp_chan holds the request behind it in its update step.
module stable_priority_queue_unit import spq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   spq_cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   spq_dpath #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_type    (req_chan.req_type),
      .item_id     (req_chan.item_id),
      .new_kind    (req_chan.new_kind),
      .new_prio    (req_chan.new_prio),
      .status      (rsp_chan.status),
      .old_count   (rsp_chan.old_count),
      .out_item    (rsp_chan.out_item),
      .out_kind    (rsp_chan.out_kind),
      .out_prio    (rsp_chan.out_prio),
      .entry_count (rsp_chan.entry_count)
   );

endmodule
